// ===== rtl/atac_pkg.sv =====
// ----------------------------------------------------------------------------
// atac_pkg: shared definitions for the allocation table access checker
// Table depths, address masking, operation and status codes, and the
// control and status structs passed between the top level and its cells.
// ----------------------------------------------------------------------------
package atac_pkg;

    localparam int LIVE_ENTRIES  = 16;
    localparam int FREED_ENTRIES = 16;
    localparam int ADDR_BITS     = 32;

    // Fixed widths of the payload fields.
    localparam int FUNC_W   = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;

    // Only the low ADDR_BITS bits of an address take part.
    localparam logic [DATA_W-1:0] ADDR_MASK = (ADDR_BITS >= DATA_W) ? {DATA_W{1'b1}} :
        DATA_W'((64'd1 << ADDR_BITS) - 64'd1);

    localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CHECK = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_VALID     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FREED     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNINIT    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_UNMATCHED = 3'd5;

    // Commands broadcast to every cell of one table.
    typedef struct packed {
        logic              append;  // tail cell takes wbase / wlen
        logic              shift;   // cells at or after the first match move up
        logic [DATA_W-1:0] addr;    // address under test
        logic [DATA_W-1:0] len;     // access length under test
        logic [DATA_W-1:0] wbase;   // entry to append
        logic [DATA_W-1:0] wlen;
    } t_cell_ctl;

    // What one cell shows its neighbors and the top level.
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] len;
        logic              contain;  // access window lies inside this entry
        logic              hit;      // a base match at this cell or an older one
        logic [DATA_W-1:0] sel_base; // entry data when this is the first match, else zero
        logic [DATA_W-1:0] sel_len;
    } t_cell_out;

endpackage

// ===== rtl/atac_cell.sv =====
// ----------------------------------------------------------------------------
// atac_cell: one entry of an ordered allocation table
// Holds a block base and length, tests the current access against it, and
// appends or takes its younger neighbor's entry on command.
// ----------------------------------------------------------------------------
module atac_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  atac_pkg::t_cell_ctl   i_ctl,
    input  logic                  i_prev_valid,
    input  logic                  i_hit_in,
    input  atac_pkg::t_cell_out   i_next,
    output atac_pkg::t_cell_out   o_cell
);
    import atac_pkg::*;

    logic              r_valid;
    logic [DATA_W-1:0] r_base;
    logic [DATA_W-1:0] r_len;

    logic tail;
    logic match;
    logic first;
    logic hit_out;
    logic contain;

    // The first empty cell after a filled one is the append position.
    assign tail    = i_prev_valid & ~r_valid;
    assign match   = r_valid & (r_base == i_ctl.addr);
    assign hit_out = i_hit_in | match;
    assign first   = match & ~i_hit_in;

    // Exact containment without overflow: base <= addr, len <= block length
    // and the offset fits in the slack.
    assign contain = r_valid & (i_ctl.addr >= r_base) & (i_ctl.len <= r_len) &
                     ((i_ctl.addr - r_base) <= (r_len - i_ctl.len));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift && hit_out) begin
            r_valid <= i_next.valid;
            r_base  <= i_next.base;
            r_len   <= i_next.len;
        end else if (i_ctl.append && tail) begin
            r_valid <= 1'b1;
            r_base  <= i_ctl.wbase;
            r_len   <= i_ctl.wlen;
        end
    end

    always_comb begin
        o_cell.valid    = r_valid;
        o_cell.base     = r_base;
        o_cell.len      = r_len;
        o_cell.contain  = contain;
        o_cell.hit      = hit_out;
        o_cell.sel_base = first ? r_base : '0;
        o_cell.sel_len  = first ? r_len : '0;
    end

endmodule

// ===== rtl/alloc_table_access_checker_unit.sv =====
// ----------------------------------------------------------------------------
// alloc_table_access_checker_unit: heap allocation tracker and access checker
// Keeps an ordered live table and an append-only freed table as chains of
// cells and answers allocate, free and check items with one status each.
// ----------------------------------------------------------------------------
// Timing: the status is registered in the cycle after the input transfer when
// the output side is free, and can be transferred out the cycle after that.
// Throughput: one item per cycle at best, since a new item is taken in the
// evaluation cycle of the previous one; an output stall holds the evaluation.
// Reset: synchronous, active low; both tables empty, no item pending, no
// result shown. Table contents need no clearing, valid bits track occupancy.
// ----------------------------------------------------------------------------
module alloc_table_access_checker_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [atac_pkg::FUNC_W-1:0]    i_func,
    input  logic [atac_pkg::DATA_W-1:0]    i_address,
    input  logic [atac_pkg::DATA_W-1:0]    i_length,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [atac_pkg::STATUS_W-1:0]  o_status
);
    import atac_pkg::*;

    // Captured item. The address is masked to ADDR_BITS on the way in, so
    // every compare downstream sees only the bits that count.
    logic                r_pend;
    logic [FUNC_W-1:0]   r_func;
    logic [DATA_W-1:0]   r_addr;
    logic [DATA_W-1:0]   r_len;

    // Output register: it parts the evaluation from the output side.
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;

    logic in_xfer;
    logic fire;

    t_cell_ctl live_ctl;
    t_cell_ctl freed_ctl;
    t_cell_out live_cell  [LIVE_ENTRIES];
    t_cell_out freed_cell [FREED_ENTRIES];

    logic              live_full;
    logic              freed_full;
    logic              found;
    logic              any_live;
    logic              any_freed;
    logic [DATA_W-1:0] sel_base;
    logic [DATA_W-1:0] sel_len;

    // The pending item is evaluated once the output register can take its
    // status. A new item is taken in that same cycle.
    assign fire       = r_pend & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = ~i_rst_n | (r_pend & ~fire);
    assign in_xfer    = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (in_xfer) begin
            r_pend <= 1'b1;
        end else if (fire) begin
            r_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_func <= i_func;
            r_addr <= i_address & ADDR_MASK;
            r_len  <= i_length;
        end
    end

    // The tables fill from cell zero, so the last cell is valid exactly when
    // the table is full.
    assign live_full  = live_cell[LIVE_ENTRIES-1].valid;
    assign freed_full = freed_cell[FREED_ENTRIES-1].valid;
    // The hit chain carries an OR of base matches from the oldest entry down.
    assign found      = live_cell[LIVE_ENTRIES-1].hit;

    // Gather containment flags and the entry picked by the first base match.
    // Only the first matching cell drives nonzero select data.
    always_comb begin
        any_live  = 1'b0;
        any_freed = 1'b0;
        sel_base  = '0;
        sel_len   = '0;
        for (int k = 0; k < LIVE_ENTRIES; k++) begin
            any_live = any_live | live_cell[k].contain;
            sel_base = sel_base | live_cell[k].sel_base;
            sel_len  = sel_len  | live_cell[k].sel_len;
        end
        for (int k = 0; k < FREED_ENTRIES; k++) begin
            any_freed = any_freed | freed_cell[k].contain;
        end
    end

    // Allocate appends at the live tail, which does nothing when the table is
    // full. A matched free moves the entry to the freed tail and closes the
    // gap in the live chain, but only if the freed table has room.
    always_comb begin
        live_ctl.append = fire & (r_func == FN_ALLOC);
        live_ctl.shift  = fire & (r_func == FN_FREE) & found & ~freed_full;
        live_ctl.addr   = r_addr;
        live_ctl.len    = r_len;
        live_ctl.wbase  = r_addr;
        live_ctl.wlen   = r_len;

        freed_ctl.append = fire & (r_func == FN_FREE) & found & ~freed_full;
        freed_ctl.shift  = 1'b0;
        freed_ctl.addr   = r_addr;
        freed_ctl.len    = r_len;
        freed_ctl.wbase  = sel_base;
        freed_ctl.wlen   = sel_len;
    end

    // A live hit wins over a freed one; neither means the window was never
    // handed out. The unused function code completes with no effect.
    always_comb begin
        case (r_func)
            FN_ALLOC: n_status = live_full ? ST_FULL : ST_DONE;
            FN_FREE: begin
                if (!found) begin
                    n_status = ST_UNMATCHED;
                end else if (freed_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_DONE;
                end
            end
            FN_CHECK: begin
                if (any_live) begin
                    n_status = ST_VALID;
                end else if (any_freed) begin
                    n_status = ST_FREED;
                end else begin
                    n_status = ST_UNINIT;
                end
            end
            default: n_status = ST_DONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

    // Live chain. Cell zero always sees a filled predecessor so it takes the
    // first allocation; the youngest cell pulls in an empty entry on a shift.
    for (genvar g = 0; g < LIVE_ENTRIES; g++) begin : g_live
        logic      prev_valid;
        logic      hit_in;
        t_cell_out next_cell;

        if (g == 0) begin : g_head
            assign prev_valid = 1'b1;
            assign hit_in     = 1'b0;
        end else begin : g_body
            assign prev_valid = live_cell[g-1].valid;
            assign hit_in     = live_cell[g-1].hit;
        end

        if (g == LIVE_ENTRIES - 1) begin : g_end
            assign next_cell = '0;
        end else begin : g_mid
            assign next_cell = live_cell[g+1];
        end

        atac_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (live_ctl),
            .i_prev_valid (prev_valid),
            .i_hit_in     (hit_in),
            .i_next       (next_cell),
            .o_cell       (live_cell[g])
        );
    end

    // Freed chain: append only, never shifted.
    for (genvar g = 0; g < FREED_ENTRIES; g++) begin : g_freed
        logic      prev_valid;
        logic      hit_in;
        t_cell_out next_cell;

        if (g == 0) begin : g_head
            assign prev_valid = 1'b1;
            assign hit_in     = 1'b0;
        end else begin : g_body
            assign prev_valid = freed_cell[g-1].valid;
            assign hit_in     = freed_cell[g-1].hit;
        end

        if (g == FREED_ENTRIES - 1) begin : g_end
            assign next_cell = '0;
        end else begin : g_mid
            assign next_cell = freed_cell[g+1];
        end

        atac_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (freed_ctl),
            .i_prev_valid (prev_valid),
            .i_hit_in     (hit_in),
            .i_next       (next_cell),
            .o_cell       (freed_cell[g])
        );
    end

endmodule

// ===== rtl/atac_checker.sv =====
// ----------------------------------------------------------------------------
// atac_checker: port-level checks for the allocation table access checker
// Watches the handshakes and the status code and is bound to the top level.
// ----------------------------------------------------------------------------
module atac_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [atac_pkg::STATUS_W-1:0] o_status
);
    import atac_pkg::*;

    // Reset leaves no result on the output.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown after reset");

    // A result that is stalled stays and keeps its status.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status))
        else $error("stalled result changed");

    // Status codes beyond the defined set never appear.
    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= ST_UNMATCHED))
        else $error("undefined status code");

    // An item taken while the output is blocked must wait, so the input
    // channel stalls until the result ahead of it is gone.
    a_in_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n && i_in_valid && !o_in_stall) && o_out_valid && i_out_stall
        |-> o_in_stall)
        else $error("input taken with a pending item and a blocked output");

endmodule

bind alloc_table_access_checker_unit atac_checker u_atac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status)
);

// ===== sim/atac_status_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atac_status_check: status predictor and comparator for the access checker
// Follows both channels of the block and replays every input transfer on its
// own copy of the live and freed tables. Each output status is compared in
// order with the oldest predicted one.
// ----------------------------------------------------------------------------
module atac_status_check (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [atac_pkg::FUNC_W-1:0]    i_func,
    input  logic [atac_pkg::DATA_W-1:0]    i_address,
    input  logic [atac_pkg::DATA_W-1:0]    i_length,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [atac_pkg::STATUS_W-1:0]  i_status,
    output int                             o_fail_count,
    output int                             o_pending
);
    import atac_pkg::*;

    logic [DATA_W-1:0]   live_base  [LIVE_ENTRIES];
    logic [DATA_W-1:0]   live_len   [LIVE_ENTRIES];
    logic [DATA_W-1:0]   freed_base [FREED_ENTRIES];
    logic [DATA_W-1:0]   freed_len  [FREED_ENTRIES];
    int                  live_used  = 0;
    int                  freed_used = 0;
    int                  mismatches = 0;
    logic [STATUS_W-1:0] status_due [$];
    logic [STATUS_W-1:0] want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Window (a, n) lies in block (b, l) when b <= a and a + n <= b + l, exactly.
    function automatic bit window_fits(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] n,
                                       input logic [DATA_W-1:0] b, input logic [DATA_W-1:0] l);
        return (a >= b) && (n <= l) && ((a - b) <= (l - n));
    endfunction

    // Applies one item to the shadow tables and returns the status it earns.
    function automatic logic [STATUS_W-1:0] apply_item(input logic [FUNC_W-1:0] fn,
                                                       input logic [DATA_W-1:0] addr_raw,
                                                       input logic [DATA_W-1:0] n);
        logic [DATA_W-1:0]   a;
        logic [STATUS_W-1:0] st;
        int                  hit;
        a   = addr_raw & ADDR_MASK;
        st  = ST_DONE;
        hit = -1;
        case (fn)
            FN_ALLOC: begin
                if (live_used >= LIVE_ENTRIES) begin
                    st = ST_FULL;
                end else begin
                    live_base[live_used] = a;
                    live_len[live_used]  = n;
                    live_used++;
                end
            end
            FN_FREE: begin
                // Scan downward so the oldest entry with this base wins.
                for (int i = live_used - 1; i >= 0; i--) begin
                    if (live_base[i] == a) hit = i;
                end
                if (hit < 0) begin
                    st = ST_UNMATCHED;
                end else if (freed_used >= FREED_ENTRIES) begin
                    st = ST_FULL;
                end else begin
                    freed_base[freed_used] = live_base[hit];
                    freed_len[freed_used]  = live_len[hit];
                    freed_used++;
                    for (int i = hit; i < live_used - 1; i++) begin
                        live_base[i] = live_base[i + 1];
                        live_len[i]  = live_len[i + 1];
                    end
                    live_used--;
                end
            end
            FN_CHECK: begin
                st = ST_UNINIT;
                for (int i = 0; i < freed_used; i++) begin
                    if (window_fits(a, n, freed_base[i], freed_len[i])) st = ST_FREED;
                end
                for (int i = 0; i < live_used; i++) begin
                    if (window_fits(a, n, live_base[i], live_len[i])) st = ST_VALID;
                end
            end
            default: begin
                st = ST_DONE;
            end
        endcase
        return st;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            live_used  = 0;
            freed_used = 0;
            status_due.delete();
        end else begin
            // The output side is handled first, so a status can never match
            // the prediction made at the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (status_due.size() == 0) begin
                    $error("status: expected none, actual %0d", i_status);
                    mismatches++;
                end else begin
                    want = status_due.pop_front();
                    if (i_status !== want) begin
                        $error("status: expected %0d, actual %0d", want, i_status);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                status_due.insert(status_due.size(),
                                  apply_item(i_func, i_address, i_length));
            end
        end
        o_pending    <= status_due.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the allocation table access checker
// Runs a directed set of allocate, free and check items over the edge cases,
// then a long random mix built around blocks it has allocated, with bursty
// input, a patterned output stall and a recurring long output hold-off. A separate
// checker predicts and compares every status.
// ----------------------------------------------------------------------------
module tb;
    import atac_pkg::*;

    // The spare function code; the block must ignore it and report done.
    localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;

    localparam int ITEM_TARGET = 1300;   // random items that do real work
    localparam int IDLE_LIMIT  = 2000;   // cycles without any transfer
    localparam int HOLD_CYCLES = 48;     // long output hold-off
    localparam int BLOCK_SLOTS = 64;     // blocks remembered for targeting
    localparam int DRAIN_WAIT  = 8;

    // Small allocations cluster here so that their windows overlap.
    localparam logic [DATA_W-1:0] HEAP_BASE = 32'h1000_0000;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    logic [FUNC_W-1:0]   i_func      = '0;
    logic [DATA_W-1:0]   i_address   = '0;
    logic [DATA_W-1:0]   i_length    = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [STATUS_W-1:0] o_status;

    int fail_count;
    int pending;
    int idle_cycles = 0;

    // Bases and lengths of the first random allocations the stimulus made.
    // Frees and checks aimed at this list target blocks that were really
    // allocated.
    logic [DATA_W-1:0] blk_base [$];
    logic [DATA_W-1:0] blk_len  [$];

    always #4 i_clk = ~i_clk;

    alloc_table_access_checker_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_address   (i_address),
        .i_length    (i_length),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status)
    );

    atac_status_check status_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_address    (i_address),
        .i_length     (i_length),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_status     (o_status),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offers one item and returns at the edge where its transfer happens.
    // The caller is always at a rising edge, so every field gets exactly one
    // nonblocking update per time step, and valid stays high between
    // back-to-back items.
    task automatic put_op(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] a,
                          input logic [DATA_W-1:0] n);
        i_in_valid <= 1'b1;
        i_func     <= fn;
        i_address  <= a;
        i_length   <= n;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // One random item. Most items are well formed: frees of bases that were
    // allocated and checks placed in, at the edges of, or just outside known
    // blocks. The rest is noise: random addresses, huge lengths and the spare
    // function code. The flag tells whether the item does real work.
    task automatic put_random_op(output bit counted);
        int                pick;
        int                shape;
        int                idx;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] l;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] n;
        logic [DATA_W-1:0] off;
        pick    = $urandom_range(0, 99);
        counted = 1'b1;
        if (pick < 4) begin
            put_op(FN_SPARE, $urandom, $urandom);
            counted = 1'b0;
        end else if (pick < 28 || blk_base.size() == 0) begin
            shape = $urandom_range(0, 15);
            if (shape == 0) begin
                // Anywhere, any size.
                b = $urandom;
                l = $urandom;
            end else if (shape < 3 && blk_base.size() != 0) begin
                // Reuse a known base so that duplicates pile up.
                b = blk_base[$urandom_range(0, blk_base.size() - 1)];
                l = $urandom_range(0, 300);
            end else begin
                b = HEAP_BASE + ($urandom_range(0, 63) << 8);
                l = $urandom_range(0, 300);
            end
            if (blk_base.size() < BLOCK_SLOTS) begin
                blk_base.insert(blk_base.size(), b);
                blk_len.insert(blk_len.size(), l);
            end
            put_op(FN_ALLOC, b, l);
        end else if (pick < 46) begin
            if ($urandom_range(0, 4) == 0) begin
                a = $urandom;
            end else begin
                a = blk_base[$urandom_range(0, blk_base.size() - 1)];
            end
            // The length is unused by a free, so it carries noise.
            put_op(FN_FREE, a, $urandom);
        end else begin
            idx   = $urandom_range(0, blk_base.size() - 1);
            b     = blk_base[idx];
            l     = blk_len[idx];
            off   = $urandom_range(0, l);
            shape = $urandom_range(0, 9);
            if (shape < 5) begin
                // Wholly inside the block.
                a = b + off;
                n = $urandom_range(0, l - off);
            end else if (shape == 5) begin
                // One byte past the end of the block.
                a = b + off;
                n = l - off + 1;
            end else if (shape == 6) begin
                // Starts one byte below the base.
                a = b - 1;
                n = $urandom_range(0, 64);
            end else if (shape == 7) begin
                // At the very end, with a length of zero to two.
                a = b + l;
                n = $urandom_range(0, 2);
            end else begin
                a = $urandom;
                n = $urandom;
            end
            put_op(FN_CHECK, a, n);
        end
    endtask

    // Output side: stretches of no stall, light stall and heavy stall, and
    // now and then a long hold-off. The first hold-off starts right after
    // reset, while the directed items are offered back to back, so the block
    // fills up and has to stall its input.
    initial begin : receiver
        int seg;
        int run;
        int pct;
        seg = 0;
        wait (i_rst_n);
        forever begin
            seg++;
            if (seg % 5 == 1) begin
                run = HOLD_CYCLES;
                pct = 100;
            end else begin
                run = $urandom_range(20, 150);
                pct = $urandom_range(0, 2) * 40;
            end
            repeat (run) begin
                @(posedge i_clk);
                i_out_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    // Watchdog: any transfer on either channel counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int counted_items;
        int burst;
        int gap;
        bit counted;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, offered back to back.
        // Empty tables: a check finds nothing, a free finds nothing, and the
        // spare code is ignored.
        put_op(FN_CHECK, 32'h0000_0000, 32'h0000_0000);
        put_op(FN_FREE, 32'h0000_1234, 32'hFFFF_FFFF);
        put_op(FN_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // A block at the top of the address space whose end lies past it:
        // the window sums must be exact, with no wrap.
        put_op(FN_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        put_op(FN_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        put_op(FN_CHECK, 32'hFFFF_FFFE, 32'h0000_0001);
        // A zero-length block holds only a zero-length access at its base.
        put_op(FN_ALLOC, 32'h2000_0000, 32'h0000_0000);
        put_op(FN_CHECK, 32'h2000_0000, 32'h0000_0000);
        put_op(FN_CHECK, 32'h2000_0000, 32'h0000_0001);
        // Two blocks with the same base; a free takes the older one.
        put_op(FN_ALLOC, 32'h3000_0000, 32'h0000_0100);
        put_op(FN_ALLOC, 32'h3000_0000, 32'h0000_0010);
        put_op(FN_CHECK, 32'h3000_0080, 32'h0000_0080);
        put_op(FN_CHECK, 32'h3000_0100, 32'h0000_0000);
        put_op(FN_CHECK, 32'h3000_0080, 32'h0000_0081);
        put_op(FN_FREE, 32'h3000_0000, 32'h0000_0000);
        put_op(FN_CHECK, 32'h3000_0080, 32'h0000_0080);
        put_op(FN_CHECK, 32'h3000_0000, 32'h0000_0010);
        put_op(FN_FREE, 32'h3000_0000, 32'h0000_0000);
        put_op(FN_CHECK, 32'h3000_0008, 32'h0000_0008);
        put_op(FN_FREE, 32'h3000_0000, 32'h0000_0000);
        // Full-length window from zero, and one starting just below a block.
        put_op(FN_CHECK, 32'h0000_0000, 32'hFFFF_FFFF);
        put_op(FN_CHECK, 32'h2FFF_FFFF, 32'h0000_0002);

        // Random part, in bursts of random length. Roughly a third of the
        // bursts run straight into the next one without a gap. The tables
        // fill along the way, which reaches both table-full cases.
        counted_items = 0;
        burst         = $urandom_range(1, 24);
        while (counted_items < ITEM_TARGET) begin
            put_random_op(counted);
            if (counted) counted_items++;
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                if ($urandom_range(0, 2) != 0) begin
                    gap = $urandom_range(1, 6);
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        i_in_valid <= 1'b0;

        // Wait for every predicted status, then keep the clock running so that a
        // stray extra result would still be caught.
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
